// File: hw/rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

  localparam int unsigned OSS = 1;
  localparam int unsigned UP_W = 16 + OSS;
  localparam int unsigned UP_SHIFT = 8 - OSS;

  localparam logic signed [63:0] B6_OFFSET = 64'sd4000;
  localparam logic signed [63:0] B7_SCALE = 64'(50000 >> OSS);
  localparam logic signed [63:0] B7_SPLIT = 64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] P_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] P_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] C_3038 = 64'sd3038;
  localparam logic signed [63:0] C_M7357 = -64'sd7357;
  localparam logic signed [63:0] C_3791 = 64'sd3791;
  localparam logic signed [63:0] C_32768 = 64'sd32768;
  localparam logic signed [63:0] T_MAX = 64'sd32767;
  localparam logic signed [63:0] T_MIN = -64'sd32768;
  localparam logic signed [63:0] PA_MAX = 64'sd1048575;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } bpc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M1,
    ST_D1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_D2,
    ST_M9,
    ST_M10,
    ST_M11,
    ST_OUT
  } bpc_state_e;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } bpc_cal_t;

  typedef struct packed {
    logic signed [16:0] dt;
    logic [UP_W-1:0]    up;
  } bpc_item_t;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] zx16(input logic [15:0] v);
    return {48'd0, v};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/barometric_pressure_compensation.sv
// flow: each item passes the front register and the queue; the back end then runs the
// shared 64-step divider (run twice) and eleven multiplies (three 32x32 partial
// products each) in turn, and takes a new item only once the last result is in its output register
// a zero divisor ends the item early; the front register and a two-entry queue take up
// to three further items meanwhile
// reset: rst_ni asynchronous active low clears control state and all five calibration registers to zero
`default_nettype none

module barometric_pressure_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        raw_temperature_i,
  input  logic [23:0]        raw_pressure_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] temperature_tenths_o,
  output logic [19:0]        pressure_pascal_o,
  output logic               status_o
);

  bpc_pkg::bpc_cal_t  cal_q;
  bpc_pkg::bpc_item_t f_item, q_item;
  logic push, full, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bpc_pkg::bpc_reg_e'(cfg_index_i))
        bpc_pkg::REG_AC1_AC2: cal_q.ac1_ac2 <= cfg_data_i;
        bpc_pkg::REG_AC3_AC4: cal_q.ac3_ac4 <= cfg_data_i;
        bpc_pkg::REG_AC5_AC6: cal_q.ac5_ac6 <= cfg_data_i;
        bpc_pkg::REG_B1_B2:   cal_q.b1_b2   <= cfg_data_i;
        bpc_pkg::REG_MC_MD:   cal_q.mc_md   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .ac6_i             (cal_q.ac5_ac6[15:0]),
    .push_o            (push),
    .item_o            (f_item),
    .full_i            (full)
  );

  bpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  bpc_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .item_valid_i         (q_valid),
    .item_i               (q_item),
    .item_pop_o           (pop),
    .cal_i                (cal_q),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .temperature_tenths_o (temperature_tenths_o),
    .pressure_pascal_o    (pressure_pascal_o),
    .status_o             (status_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bpc_front.sv
`default_nettype none

module bpc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           raw_temperature_i,
  input  logic [23:0]           raw_pressure_i,
  input  logic [15:0]           ac6_i,
  output logic                  push_o,
  output bpc_pkg::bpc_item_t    item_o,
  input  logic                  full_i
);

  logic               valid_q, valid_d;
  bpc_pkg::bpc_item_t item_q, item_d;
  logic               accept;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d      = 1'b1;
      item_d.dt    = signed'({1'b0, raw_temperature_i}) - signed'({1'b0, ac6_i});
      item_d.up    = raw_pressure_i[23:bpc_pkg::UP_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/bpc_queue.sv
`default_nettype none

module bpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bpc_pkg::bpc_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output bpc_pkg::bpc_item_t item_o,
  input  logic               pop_i
);

  bpc_pkg::bpc_item_t mem_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bpc_mul.sv
`default_nettype none

module bpc_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic        busy_q, done_q, neg_q;
  logic [1:0]  cnt_q;
  logic [63:0] am_q, bm_q, acc_q;
  logic [31:0] as, bs;
  logic [63:0] pp, pp_sh;

  always_comb begin
    as = (cnt_q == 2'd2) ? am_q[63:32] : am_q[31:0];
    bs = (cnt_q == 2'd1) ? bm_q[63:32] : bm_q[31:0];
    pp = {32'd0, as} * {32'd0, bs};
    pp_sh = (cnt_q == 2'd0) ? pp : {pp[31:0], 32'd0};
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      bm_q  <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= 64'd0;
    end else if (busy_q) begin
      if (cnt_q == 2'd3) begin
        res_o <= neg_q ? -signed'(acc_q) : signed'(acc_q);
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bpc_div.sv
`default_nettype none

module bpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] d_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic        busy_q, done_q, neg_q;
  logic [6:0]  cnt_q;
  logic [63:0] rem_q, quo_q, dm_q;
  logic [64:0] sh, diff;

  always_comb begin
    sh   = {rem_q, quo_q[63]};
    diff = sh - {1'b0, dm_q};
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q[6]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= n_i[63] ? 64'(-n_i) : 64'(n_i);
      dm_q  <= d_i[63] ? 64'(-d_i) : 64'(d_i);
      neg_q <= n_i[63] ^ d_i[63];
      rem_q <= 64'd0;
    end else if (busy_q) begin
      if (cnt_q[6]) begin
        res_o <= neg_q ? -signed'(quo_q) : signed'(quo_q);
      end else if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bpc_back.sv
`default_nettype none

module bpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  bpc_pkg::bpc_item_t  item_i,
  output logic                item_pop_o,
  input  bpc_pkg::bpc_cal_t   cal_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  temperature_tenths_o,
  output logic [19:0]         pressure_pascal_o,
  output logic                status_o
);

  bpc_pkg::bpc_state_e st_q, st_d;
  logic launched_q, launched_d, err_q, err_d;
  logic signed [16:0] dt_q, dt_d;
  logic [bpc_pkg::UP_W-1:0] up_q, up_d;
  logic signed [63:0] x1_q, x1_d, den_q, den_d, b6_q, b6_d, sq_q, sq_d;
  logic signed [63:0] acc_q, acc_d, b3_q, b3_d, b4_q, b4_d, b7_q, b7_d, p_q, p_d;
  logic signed [15:0] t_q, t_d;
  logic [19:0] pa_q, pa_d;
  logic ov_q, ov_d, stat_q, stat_d;
  logic signed [15:0] temp_q, temp_d;
  logic [19:0] pres_q, pres_d;

  logic mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_a, mul_b, mul_res, div_n, div_d, div_res;
  logic compute, use_div, fire, big;
  logic signed [63:0] m15, den_new;

  logic signed [63:0] ac1, ac2, ac3, ac4, ac5, b1, b2, mc, md;

  assign ac1 = bpc_pkg::sx16(cal_i.ac1_ac2[31:16]);
  assign ac2 = bpc_pkg::sx16(cal_i.ac1_ac2[15:0]);
  assign ac3 = bpc_pkg::sx16(cal_i.ac3_ac4[31:16]);
  assign ac4 = bpc_pkg::zx16(cal_i.ac3_ac4[15:0]);
  assign ac5 = bpc_pkg::zx16(cal_i.ac5_ac6[31:16]);
  assign b1  = bpc_pkg::sx16(cal_i.b1_b2[31:16]);
  assign b2  = bpc_pkg::sx16(cal_i.b1_b2[15:0]);
  assign mc  = bpc_pkg::sx16(cal_i.mc_md[31:16]);
  assign md  = bpc_pkg::sx16(cal_i.mc_md[15:0]);

  assign compute = (st_q != bpc_pkg::ST_IDLE) && (st_q != bpc_pkg::ST_OUT);
  assign use_div = (st_q == bpc_pkg::ST_D1) || (st_q == bpc_pkg::ST_D2);
  assign fire    = launched_q && (use_div ? div_done : mul_done);
  assign m15     = mul_res >>> 15;
  assign den_new = m15 + md;
  assign big     = b7_q >= bpc_pkg::B7_SPLIT;

  bpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  bpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      bpc_pkg::ST_IDLE: if (item_valid_i) st_d = bpc_pkg::ST_M1;
      bpc_pkg::ST_M1:   if (fire) st_d = (den_new == 64'sd0) ? bpc_pkg::ST_OUT : bpc_pkg::ST_D1;
      bpc_pkg::ST_D1:   if (fire) st_d = bpc_pkg::ST_M2;
      bpc_pkg::ST_M2:   if (fire) st_d = bpc_pkg::ST_M3;
      bpc_pkg::ST_M3:   if (fire) st_d = bpc_pkg::ST_M4;
      bpc_pkg::ST_M4:   if (fire) st_d = bpc_pkg::ST_M5;
      bpc_pkg::ST_M5:   if (fire) st_d = bpc_pkg::ST_M6;
      bpc_pkg::ST_M6:   if (fire) st_d = bpc_pkg::ST_M7;
      bpc_pkg::ST_M7:   if (fire) st_d = (m15 == 64'sd0) ? bpc_pkg::ST_OUT : bpc_pkg::ST_M8;
      bpc_pkg::ST_M8:   if (fire) st_d = bpc_pkg::ST_D2;
      bpc_pkg::ST_D2:   if (fire) st_d = bpc_pkg::ST_M9;
      bpc_pkg::ST_M9:   if (fire) st_d = bpc_pkg::ST_M10;
      bpc_pkg::ST_M10:  if (fire) st_d = bpc_pkg::ST_M11;
      bpc_pkg::ST_M11:  if (fire) st_d = bpc_pkg::ST_OUT;
      bpc_pkg::ST_OUT:  if (!ov_q || !out_stall_i) st_d = bpc_pkg::ST_IDLE;
      default:          st_d = bpc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic signed [63:0] b5, tt, x3, s, pr, pf;
    b5 = x1_q + div_res;
    tt = (b5 + 64'sd8) >>> 4;
    x3 = acc_q + (mul_res >>> 11);
    s  = (ac1 <<< 2) + x3;
    pr = big ? (div_res <<< 1) : div_res;
    pf = p_q + ((acc_q + (mul_res >>> 16) + bpc_pkg::C_3791) >>> 4);

    launched_d = launched_q;
    err_d = err_q;
    dt_d = dt_q;
    up_d = up_q;
    x1_d = x1_q;
    den_d = den_q;
    b6_d = b6_q;
    sq_d = sq_q;
    acc_d = acc_q;
    b3_d = b3_q;
    b4_d = b4_q;
    b7_d = b7_q;
    p_d = p_q;
    t_d = t_q;
    pa_d = pa_q;
    ov_d = ov_q;
    temp_d = temp_q;
    pres_d = pres_q;
    stat_d = stat_q;
    item_pop_o = 1'b0;
    mul_a = 64'sd0;
    mul_b = 64'sd0;
    div_n = 64'sd0;
    div_d = 64'sd1;
    mul_start = compute && !use_div && !launched_q;
    div_start = compute && use_div && !launched_q;
    if (compute && !launched_q) begin
      launched_d = 1'b1;
    end
    if (fire) begin
      launched_d = 1'b0;
    end
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      bpc_pkg::ST_IDLE: begin
        item_pop_o = item_valid_i;
        if (item_valid_i) begin
          dt_d  = item_i.dt;
          up_d  = item_i.up;
          err_d = 1'b0;
        end
      end
      bpc_pkg::ST_M1: begin
        mul_a = {{47{dt_q[16]}}, dt_q};
        mul_b = ac5;
        if (fire) begin
          x1_d  = m15;
          den_d = den_new;
          if (den_new == 64'sd0) err_d = 1'b1;
        end
      end
      bpc_pkg::ST_D1: begin
        div_n = mc <<< 11;
        div_d = den_q;
        if (fire) begin
          b6_d = b5 - bpc_pkg::B6_OFFSET;
          if (tt > bpc_pkg::T_MAX) t_d = 16'sh7FFF;
          else if (tt < bpc_pkg::T_MIN) t_d = 16'sh8000;
          else t_d = tt[15:0];
        end
      end
      bpc_pkg::ST_M2: begin
        mul_a = b6_q;
        mul_b = b6_q;
        if (fire) sq_d = mul_res >>> 12;
      end
      bpc_pkg::ST_M3: begin
        mul_a = b2;
        mul_b = sq_q;
        if (fire) acc_d = mul_res >>> 11;
      end
      bpc_pkg::ST_M4: begin
        mul_a = ac2;
        mul_b = b6_q;
        if (fire) b3_d = ((s <<< bpc_pkg::OSS) + 64'sd2) >>> 2;
      end
      bpc_pkg::ST_M5: begin
        mul_a = ac3;
        mul_b = b6_q;
        if (fire) acc_d = mul_res >>> 13;
      end
      bpc_pkg::ST_M6: begin
        mul_a = b1;
        mul_b = sq_q;
        if (fire) begin
          acc_d = ((acc_q + (mul_res >>> 16) + 64'sd2) >>> 2) + bpc_pkg::C_32768;
        end
      end
      bpc_pkg::ST_M7: begin
        mul_a = ac4;
        mul_b = acc_q;
        if (fire) begin
          b4_d = m15;
          if (m15 == 64'sd0) err_d = 1'b1;
        end
      end
      bpc_pkg::ST_M8: begin
        mul_a = signed'({{(64-bpc_pkg::UP_W){1'b0}}, up_q}) - b3_q;
        mul_b = bpc_pkg::B7_SCALE;
        if (fire) b7_d = mul_res;
      end
      bpc_pkg::ST_D2: begin
        div_n = big ? b7_q : (b7_q <<< 1);
        div_d = b4_q;
        if (fire) begin
          if (pr > bpc_pkg::P_MAX) p_d = bpc_pkg::P_MAX;
          else if (pr < bpc_pkg::P_MIN) p_d = bpc_pkg::P_MIN;
          else p_d = pr;
        end
      end
      bpc_pkg::ST_M9: begin
        mul_a = p_q >>> 8;
        mul_b = p_q >>> 8;
        if (fire) acc_d = mul_res;
      end
      bpc_pkg::ST_M10: begin
        mul_a = acc_q;
        mul_b = bpc_pkg::C_3038;
        if (fire) acc_d = mul_res >>> 16;
      end
      bpc_pkg::ST_M11: begin
        mul_a = bpc_pkg::C_M7357;
        mul_b = p_q;
        if (fire) begin
          if (pf > bpc_pkg::PA_MAX) pa_d = 20'hFFFFF;
          else if (pf < 64'sd0) pa_d = 20'd0;
          else pa_d = pf[19:0];
        end
      end
      bpc_pkg::ST_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d   = 1'b1;
          temp_d = err_q ? 16'sd0 : t_q;
          pres_d = err_q ? 20'd0 : pa_q;
          stat_d = err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = ov_q;
  assign temperature_tenths_o = temp_q;
  assign pressure_pascal_o    = pres_q;
  assign status_o             = stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= bpc_pkg::ST_IDLE;
      launched_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      st_q       <= st_d;
      launched_q <= launched_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    dt_q   <= dt_d;
    up_q   <= up_d;
    x1_q   <= x1_d;
    den_q  <= den_d;
    b6_q   <= b6_d;
    sq_q   <= sq_d;
    acc_q  <= acc_d;
    b3_q   <= b3_d;
    b4_q   <= b4_d;
    b7_q   <= b7_d;
    p_q    <= p_d;
    t_q    <= t_d;
    pa_q   <= pa_d;
    temp_q <= temp_d;
    pres_q <= pres_d;
    stat_q <= stat_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/bpc_checker.sv
`default_nettype none

module bpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] temperature_tenths_o,
  input logic [19:0]        pressure_pascal_o,
  input logic               status_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temperature_tenths_o)
      && $stable(pressure_pascal_o) && $stable(status_o))
    else $error("result changed under stall");

  // error result carries zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> temperature_tenths_o == 16'sd0 && pressure_pascal_o == 20'd0)
    else $error("error result not zero");

  // nothing pending right after reset
  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("state not cleared by reset");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

`default_nettype wire

// File: tb/tb_barometric_pressure_compensation.sv
`default_nettype none

module tb_barometric_pressure_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 53;
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [19:0]        pa;
    logic               st;
  } reading_t;

  typedef struct packed {
    logic [2:0]  cal;
    logic [15:0] ut;
    logic [23:0] up;
    logic        typed;
    reading_t    want;
  } row_t;

  localparam reading_t DIV_ZERO = '{temp: 16'sd0, pa: 20'd0, st: 1'b1};
  localparam reading_t NONE = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] raw_temperature_i = '0;
  logic [23:0] raw_pressure_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] temperature_tenths_o;
  logic [19:0] pressure_pascal_o;
  logic status_o;

  barometric_pressure_compensation dut (.*);

  always #6 clk_i = ~clk_i;

  bpc_pkg::bpc_cal_t cal_model = '0;
  bpc_pkg::bpc_cal_t cal_sets [6];
  reading_t reading_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bit failed = 1'b0;

  row_t dir_rows [20] = '{
    '{3'd0, 16'h0000, 24'h000000, 1'b1, DIV_ZERO},
    '{3'd0, 16'hFFFF, 24'hFFFFFF, 1'b1, DIV_ZERO},
    '{3'd0, 16'h5555, 24'hAAAAAA, 1'b1, DIV_ZERO},
    '{3'd1, 16'd27898, 24'h5D2300, 1'b0, NONE},
    '{3'd1, 16'h0000, 24'h000000, 1'b0, NONE},
    '{3'd1, 16'hFFFF, 24'hFFFFFF, 1'b0, NONE},
    '{3'd1, 16'h0000, 24'hFFFFFF, 1'b0, NONE},
    '{3'd1, 16'hFFFF, 24'h000000, 1'b0, NONE},
    '{3'd1, 16'h8000, 24'h800000, 1'b0, NONE},
    '{3'd1, 16'h7FFF, 24'h7FFFFF, 1'b0, NONE},
    '{3'd2, 16'd27898, 24'h5D2300, 1'b1, DIV_ZERO},
    '{3'd2, 16'hFFFF, 24'hFFFFFF, 1'b1, DIV_ZERO},
    '{3'd5, 16'd23153, 24'h5D2300, 1'b1, DIV_ZERO},
    '{3'd5, 16'd27898, 24'h5D2300, 1'b0, NONE},
    '{3'd3, 16'h0000, 24'h000000, 1'b0, NONE},
    '{3'd3, 16'hFFFF, 24'hFFFFFF, 1'b0, NONE},
    '{3'd3, 16'h1234, 24'hABCDEF, 1'b0, NONE},
    '{3'd4, 16'h0000, 24'hFFFFFF, 1'b0, NONE},
    '{3'd4, 16'hFFFF, 24'h000000, 1'b0, NONE},
    '{3'd4, 16'h8001, 24'h00FF00, 1'b0, NONE}
  };

  function automatic reading_t compensate(input logic [15:0] ut_raw,
                                          input logic [23:0] p_raw,
                                          input bpc_pkg::bpc_cal_t c);
    reading_t r;
    longint ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint x1, x2, x3, den, b3, b4, b5, b6, b7, sq, t, p, q;
    r = DIV_ZERO;
    ut = longint'(ut_raw);
    up = longint'(p_raw >> bpc_pkg::UP_SHIFT);
    ac1 = longint'($signed(c.ac1_ac2[31:16]));
    ac2 = longint'($signed(c.ac1_ac2[15:0]));
    ac3 = longint'($signed(c.ac3_ac4[31:16]));
    ac4 = longint'(c.ac3_ac4[15:0]);
    ac5 = longint'(c.ac5_ac6[31:16]);
    ac6 = longint'(c.ac5_ac6[15:0]);
    b1 = longint'($signed(c.b1_b2[31:16]));
    b2 = longint'($signed(c.b1_b2[15:0]));
    mc = longint'($signed(c.mc_md[31:16]));
    md = longint'($signed(c.mc_md[15:0]));
    x1 = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << bpc_pkg::OSS) + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = (ac4 * (x3 + 32768)) >>> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * longint'(50000 >> bpc_pkg::OSS);
    if (b7 < 64'sd2147483648) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    q = p >>> 8;
    x1 = (q * q * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p > 1048575) p = 1048575;
    if (p < 0) p = 0;
    r.temp = t[15:0];
    r.pa = p[19:0];
    r.st = 1'b0;
    return r;
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (reading_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bpc_pkg::REG_AC1_AC2: cal_model.ac1_ac2 = data;
      bpc_pkg::REG_AC3_AC4: cal_model.ac3_ac4 = data;
      bpc_pkg::REG_AC5_AC6: cal_model.ac5_ac6 = data;
      bpc_pkg::REG_B1_B2:   cal_model.b1_b2 = data;
      bpc_pkg::REG_MC_MD:   cal_model.mc_md = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_cal(input bpc_pkg::bpc_cal_t c);
    wait_idle();
    write_reg(bpc_pkg::REG_AC1_AC2, c.ac1_ac2);
    write_reg(bpc_pkg::REG_AC3_AC4, c.ac3_ac4);
    write_reg(bpc_pkg::REG_AC5_AC6, c.ac5_ac6);
    write_reg(bpc_pkg::REG_B1_B2, c.b1_b2);
    write_reg(bpc_pkg::REG_MC_MD, c.mc_md);
  endtask

  task automatic send_sample(input logic [15:0] ut, input logic [23:0] up,
                             input bit typed, input reading_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= ut;
    raw_pressure_i <= up;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reading_q.push_back(typed ? want : compensate(ut, up, cal_model));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_half(input logic [15:0] base);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return base + 16'($urandom_range(511)) - 16'd256;
  endfunction

  function automatic bpc_pkg::bpc_cal_t rand_cal();
    bpc_pkg::bpc_cal_t c;
    c = cal_sets[1];
    if ($urandom_range(4) == 0) return bpc_pkg::bpc_cal_t'({$urandom, $urandom, $urandom,
                                                            $urandom, $urandom});
    c.ac1_ac2 = {rand_half(c.ac1_ac2[31:16]), rand_half(c.ac1_ac2[15:0])};
    c.ac3_ac4 = {rand_half(c.ac3_ac4[31:16]), rand_half(c.ac3_ac4[15:0])};
    c.ac5_ac6 = {rand_half(c.ac5_ac6[31:16]), rand_half(c.ac5_ac6[15:0])};
    c.b1_b2 = {rand_half(c.b1_b2[31:16]), rand_half(c.b1_b2[15:0])};
    c.mc_md = {rand_half(c.mc_md[31:16]), rand_half(c.mc_md[15:0])};
    return c;
  endfunction

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    reading_t exp_r;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (out_valid_o && !out_stall_i) begin
      if (reading_q.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1'b1;
      end else begin
        exp_r = reading_q.pop_front();
        if (temperature_tenths_o !== exp_r.temp) begin
          $error("temperature_tenths expected %0d actual %0d", exp_r.temp,
                 temperature_tenths_o);
          failed = 1'b1;
        end
        if (pressure_pascal_o !== exp_r.pa) begin
          $error("pressure_pascal expected %0d actual %0d", exp_r.pa,
                 pressure_pascal_o);
          failed = 1'b1;
        end
        if (status_o !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, status_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int cur_cal;
    int mode;
    logic [15:0] ut;
    cal_sets[0] = '0;
    cal_sets[1] = '{32'h0198FFB8, 32'hC7D17FE5, 32'h7FF55A71, 32'h182E0004, 32'hDDF90B34};
    cal_sets[2] = cal_sets[1];
    cal_sets[2].ac3_ac4 = 32'hC7D10000;
    cal_sets[3] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    cal_sets[4] = '{32'h7FFF8000, 32'h8000FFFF, 32'hFFFF0000, 32'h7FFF8000, 32'h80007FFF};
    cal_sets[5] = cal_sets[1];
    cal_sets[5].mc_md = 32'hDDF90000;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cur_cal = 0;
    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].cal) != cur_cal) begin
        cur_cal = int'(dir_rows[i].cal);
        load_cal(cal_sets[cur_cal]);
      end
      send_sample(dir_rows[i].ut, dir_rows[i].up, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 56 : (mode == 3) ? 23 : 0;
      recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 23 : 0;
      load_cal(rand_cal());
      write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ut = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 35000));
        send_sample(ut, 24'($urandom), 1'b0, NONE);
      end
    end

    wait_idle();
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: barometric_pressure_compensation.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_queue.sv
hw/rtl/bpc_mul.sv
hw/rtl/bpc_div.sv
hw/rtl/bpc_back.sv
hw/rtl/barometric_pressure_compensation.sv
hw/rtl/bpc_checker.sv
tb/tb_barometric_pressure_compensation.sv
